FILE: sv/lcmt_pkg.sv
// ---------------------------------------------------------------------------
// lcmt_pkg
// Shared constants and types for the maximum line tree core: field widths,
// request codes, default geometry and the node store command bundle.
// ---------------------------------------------------------------------------
package lcmt_pkg;

   localparam int SPAN_HALF_DEF  = 1024;
   localparam int TREE_NODES_DEF = 8192;

   localparam int COEF_W = 32;              // slope and intercept width
   localparam int LINE_W = 2 * COEF_W;      // packed line: slope high, intercept low
   localparam int OPND_W = COEF_W + 1;      // difference of two coefficients
   localparam int XIN_W  = 12;              // query coordinate width
   localparam int OUT_W  = 43;              // result value width

   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic rd_en;
      logic wr_line;
      logic wr_valid;
      logic valid_bit;
   } store_cmd_type;

endpackage

FILE: sv/lcmt_eval_unit.sv
// ---------------------------------------------------------------------------
// lcmt_eval_unit
// Shared line evaluator: k * x + c in two registered stages, multiply then
// add. A new evaluation can be issued every cycle; its sum comes out of the
// second stage register.
// ---------------------------------------------------------------------------
module lcmt_eval_unit
   import lcmt_pkg::*;
#(
   parameter int XW = 12
) (
   input  logic                       clock,
   input  logic signed [OPND_W-1:0]   op_k,
   input  logic signed [OPND_W-1:0]   op_c,
   input  logic signed [XW-1:0]       op_x,
   output logic signed [OPND_W+XW:0]  sum
);

   localparam int PW = OPND_W + XW;

   logic signed [PW-1:0]     prod_ff;
   logic signed [OPND_W-1:0] addend_ff;
   logic signed [PW:0]       sum_ff;

   always_ff @(posedge clock) begin
      prod_ff   <= op_k * op_x;
      addend_ff <= op_c;
      sum_ff    <= (PW+1)'(prod_ff) + (PW+1)'(addend_ff);
   end

   assign sum = sum_ff;

endmodule

FILE: sv/lcmt_node_store.sv
// ---------------------------------------------------------------------------
// lcmt_node_store
// Heap-indexed node memories: one line word and one occupancy bit per node.
// One read port and one write port, registered read data.
// ---------------------------------------------------------------------------
module lcmt_node_store
   import lcmt_pkg::*;
#(
   parameter int TREE_NODES = TREE_NODES_DEF,
   parameter int AW         = $clog2(TREE_NODES)
) (
   input  logic              clock,
   input  store_cmd_type     cmd,
   input  logic [AW-1:0]     rd_addr,
   input  logic [AW-1:0]     wr_addr,
   input  logic [LINE_W-1:0] wr_data,
   output logic [LINE_W-1:0] rd_line,
   output logic              rd_valid
);

   logic [LINE_W-1:0] line_mem [TREE_NODES];
   logic              valid_mem [TREE_NODES];
   logic [LINE_W-1:0] rd_line_ff;
   logic              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_line) begin
         line_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_line_ff <= line_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_valid) begin
         valid_mem[wr_addr] <= cmd.valid_bit;
      end
      if (cmd.rd_en) begin
         rd_valid_ff <= valid_mem[rd_addr];
      end
   end

   assign rd_line  = rd_line_ff;
   assign rd_valid = rd_valid_ff;

endmodule

FILE: sv/li_chao_max_line_tree_core.sv
// ---------------------------------------------------------------------------
// li_chao_max_line_tree_core
// Maximum line tree over x in [-SPAN_HALF, SPAN_HALF]: add lines, query the
// highest line value at a point.
// ---------------------------------------------------------------------------
// After reset the core runs a clearing pass over the occupancy bits of all
// TREE_NODES nodes with busy high. A transaction is taken when start is
// high and busy is low, and busy stays high until the walk ends. Each
// visited tree level of an add goes through a read, three evaluations of
// the difference line through the one shared multiplier and a decide step;
// a query level goes through a read, one evaluation and an update. The
// shared multiply-add unit and the single read port of the node memory
// are why these steps run one after another. A query returns exactly one
// result on rsp_valid, held for one cycle only: the receiver must take it
// then. An add returns nothing.
// ---------------------------------------------------------------------------
module li_chao_max_line_tree_core
   import lcmt_pkg::*;
#(
   parameter int SPAN_HALF  = SPAN_HALF_DEF,
   parameter int TREE_NODES = TREE_NODES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_type,
   input  logic signed [COEF_W-1:0] req_slope,
   input  logic signed [COEF_W-1:0] req_intercept,
   input  logic signed [XIN_W-1:0]  req_x_point,
   output logic                     rsp_valid,
   output logic signed [OUT_W-1:0]  rsp_max_value,
   output logic                     rsp_empty_res
);

   localparam int AW = $clog2(TREE_NODES);
   localparam int IW = AW + 1;
   localparam int XW = $clog2(SPAN_HALF) + 2;
   localparam int UW = $clog2(2 * SPAN_HALF + 1);
   localparam int SW = OPND_W + XW + 1;
   localparam int CW = ((XW > XIN_W) ? XW : XIN_W) + 1;

   localparam logic signed [CW-1:0] X_MAX = CW'(SPAN_HALF);
   localparam logic signed [CW-1:0] X_MIN = -X_MAX;

   typedef enum logic [10:0] {
      ST_CLEAR  = 11'b000_0000_0001,
      ST_IDLE   = 11'b000_0000_0010,
      ST_CHECK  = 11'b000_0000_0100,
      ST_EV0    = 11'b000_0000_1000,
      ST_EV1    = 11'b000_0001_0000,
      ST_EV2    = 11'b000_0010_0000,
      ST_EV3    = 11'b000_0100_0000,
      ST_DECIDE = 11'b000_1000_0000,
      ST_QEV0   = 11'b001_0000_0000,
      ST_QEV1   = 11'b010_0000_0000,
      ST_QUPD   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [AW-1:0]             clr_ff, clr_in;
   logic [IW-1:0]             idx_ff, idx_in;
   logic [UW-1:0]             lo_ff, lo_in;
   logic [UW-1:0]             hi_ff, hi_in;
   logic [UW-1:0]             u_ff, u_in;
   logic                      type_ff, type_in;
   logic [COEF_W-1:0]         k_ff, k_in;
   logic [COEF_W-1:0]         c_ff, c_in;
   logic signed [OPND_W-1:0]  opk_ff, opk_in;
   logic signed [OPND_W-1:0]  opc_ff, opc_in;
   logic                      dlo_neg_ff, dlo_neg_in;
   logic                      dhi_neg_ff, dhi_neg_in;
   logic signed [SW-1:0]      best_ff, best_in;
   logic                      found_ff, found_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                      rsp_empty_ff, rsp_empty_in;

   store_cmd_type             cmd;
   logic [AW-1:0]             rd_addr;
   logic [AW-1:0]             wr_addr;
   logic [LINE_W-1:0]         rd_line;
   logic                      rd_valid;
   logic [COEF_W-1:0]         node_k;
   logic [COEF_W-1:0]         node_c;

   logic                      accept;
   logic [UW:0]               mid_sum;
   logic [UW-1:0]             mid;
   logic [UW-1:0]             coord_sel;
   logic signed [UW:0]        x_diff;
   logic signed [XW-1:0]      op_x;
   logic signed [SW-1:0]      sum;
   logic                      dm_neg;
   logic                      dm_pos;
   logic                      swap;
   logic                      go_right;
   logic [IW-1:0]             next_idx;
   logic                      next_ok;
   logic signed [SW-1:0]      new_best;
   logic signed [CW-1:0]      x_ext;
   logic signed [CW-1:0]      x_clamp;
   logic signed [CW-1:0]      u_full;
   logic signed [SW+OUT_W-1:0] best_wide;
   logic                      resp_fire;
   logic signed [SW-1:0]      resp_best;
   logic                      resp_found;

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff != ST_IDLE);
   assign node_k  = rd_line[LINE_W-1:COEF_W];
   assign node_c  = rd_line[COEF_W-1:0];

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[UW:1];

   always_comb begin
      unique case (state_ff)
         ST_EV0:  coord_sel = lo_ff;
         ST_EV1:  coord_sel = hi_ff;
         ST_EV2:  coord_sel = mid;
         default: coord_sel = u_ff;
      endcase
   end

   assign x_diff = $signed({1'b0, coord_sel}) - $signed((UW+1)'(SPAN_HALF));
   assign op_x   = x_diff[XW-1:0];

   lcmt_eval_unit #(
      .XW (XW)
   ) u_eval (
      .clock (clock),
      .op_k  (opk_ff),
      .op_c  (opc_ff),
      .op_x  (op_x),
      .sum   (sum)
   );

   lcmt_node_store #(
      .TREE_NODES (TREE_NODES),
      .AW         (AW)
   ) u_store (
      .clock    (clock),
      .cmd      (cmd),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .wr_data  ({k_ff, c_ff}),
      .rd_line  (rd_line),
      .rd_valid (rd_valid)
   );

   assign wr_addr = (state_ff == ST_CLEAR) ? clr_ff : idx_ff[AW-1:0];

   assign x_ext   = CW'(req_x_point);
   assign x_clamp = (x_ext < X_MIN) ? X_MIN : ((x_ext > X_MAX) ? X_MAX : x_ext);
   assign u_full  = x_clamp + X_MAX;

   assign dm_neg   = sum[SW-1];
   assign dm_pos   = !sum[SW-1] && (sum != '0);
   assign swap     = dlo_neg_ff;
   assign new_best = (!found_ff || (sum > best_ff)) ? sum : best_ff;

   always_comb begin
      if (state_ff == ST_QUPD) begin
         go_right = (u_ff > mid);
      end else begin
         go_right = swap ? dm_neg : dm_pos;
      end
   end

   assign next_idx = {idx_ff[IW-2:0], go_right};
   assign next_ok  = (next_idx < IW'(TREE_NODES));
   assign rd_addr  = accept ? AW'(1) : next_idx[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      u_in         = u_ff;
      type_in      = type_ff;
      k_in         = k_ff;
      c_in         = c_ff;
      opk_in       = opk_ff;
      opc_in       = opc_ff;
      dlo_neg_in   = dlo_neg_ff;
      dhi_neg_in   = dhi_neg_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      cmd          = '0;
      resp_fire    = 1'b0;
      resp_best    = best_ff;
      resp_found   = found_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            cmd.wr_valid  = 1'b1;
            cmd.valid_bit = 1'b0;
            clr_in        = clr_ff + AW'(1);
            if (clr_ff == AW'(TREE_NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.rd_en = 1'b1;
               idx_in    = IW'(1);
               lo_in     = '0;
               hi_in     = UW'(2 * SPAN_HALF);
               u_in      = u_full[UW-1:0];
               type_in   = req_type;
               k_in      = req_slope;
               c_in      = req_intercept;
               best_in   = '0;
               found_in  = 1'b0;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (type_ff == REQ_ADD) begin
               if (!rd_valid) begin
                  cmd.wr_line   = 1'b1;
                  cmd.wr_valid  = 1'b1;
                  cmd.valid_bit = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  opk_in   = $signed({node_k[COEF_W-1], node_k}) -
                             $signed({k_ff[COEF_W-1], k_ff});
                  opc_in   = $signed({node_c[COEF_W-1], node_c}) -
                             $signed({c_ff[COEF_W-1], c_ff});
                  state_in = ST_EV0;
               end
            end else begin
               if (!rd_valid) begin
                  resp_fire = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  opk_in   = $signed({node_k[COEF_W-1], node_k});
                  opc_in   = $signed({node_c[COEF_W-1], node_c});
                  state_in = ST_QEV0;
               end
            end
         end
         ST_EV0: begin
            state_in = ST_EV1;
         end
         ST_EV1: begin
            state_in = ST_EV2;
         end
         ST_EV2: begin
            dlo_neg_in = sum[SW-1];
            state_in   = ST_EV3;
         end
         ST_EV3: begin
            dhi_neg_in = sum[SW-1];
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!dlo_neg_ff && !dhi_neg_ff) begin
               state_in = ST_IDLE;
            end else if (dlo_neg_ff && dhi_neg_ff) begin
               cmd.wr_line = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               // node keeps its line when it wins its half; else swap in the new one
               if (!(go_right ^ swap)) begin
                  cmd.wr_line = 1'b1;
                  k_in        = node_k;
                  c_in        = node_c;
               end
               if (go_right) begin
                  lo_in = mid + UW'(1);
               end else begin
                  hi_in = mid;
               end
               idx_in = next_idx;
               if (next_ok) begin
                  cmd.rd_en = 1'b1;
                  state_in  = ST_CHECK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_QEV0: begin
            state_in = ST_QEV1;
         end
         ST_QEV1: begin
            state_in = ST_QUPD;
         end
         ST_QUPD: begin
            best_in    = new_best;
            found_in   = 1'b1;
            resp_best  = new_best;
            resp_found = 1'b1;
            if (lo_ff == hi_ff) begin
               resp_fire = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               if (go_right) begin
                  lo_in = mid + UW'(1);
               end else begin
                  hi_in = mid;
               end
               idx_in = next_idx;
               if (next_ok) begin
                  cmd.rd_en = 1'b1;
                  state_in  = ST_CHECK;
               end else begin
                  resp_fire = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign best_wide    = {{OUT_W{resp_best[SW-1]}}, resp_best};
   assign rsp_valid_in = resp_fire;
   assign rsp_value_in = resp_found ? best_wide[OUT_W-1:0] : '0;
   assign rsp_empty_in = !resp_found;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      u_ff       <= u_in;
      type_ff    <= type_in;
      k_ff       <= k_in;
      c_ff       <= c_in;
      opk_ff     <= opk_in;
      opc_ff     <= opc_in;
      dlo_neg_ff <= dlo_neg_in;
      dhi_neg_ff <= dhi_neg_in;
      best_ff    <= best_in;
      found_ff   <= found_in;
      if (resp_fire) begin
         rsp_value_ff <= rsp_value_in;
         rsp_empty_ff <= rsp_empty_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_max_value = rsp_value_ff;
   assign rsp_empty_res = rsp_empty_ff;

endmodule

FILE: sv/lcmt_checker.sv
// ---------------------------------------------------------------------------
// lcmt_checker
// Port-level checks on the line tree core: clearing after reset, busy right
// after a transaction is taken, isolated result strobes, empty results.
// ---------------------------------------------------------------------------
module lcmt_checker
   import lcmt_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_valid,
   input logic signed [OUT_W-1:0] rsp_max_value,
   input logic                    rsp_empty_res
);

   logic accept;

   assign accept = start && !busy;

   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> busy)
      else $error("core not clearing after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy low right after a transaction was taken");

   a_no_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !rsp_valid)
      else $error("result strobe right after a transaction was taken");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> (rsp_max_value == '0))
      else $error("empty result carries a nonzero value");

endmodule

bind li_chao_max_line_tree_core lcmt_checker u_lcmt_checker (.*);

FILE: test/line_tree_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_tree_checker
// Watches the request and response channels of the maximum line tree core.
// It keeps its own copy of the node store and valid bits, inserts each
// accepted line the way the core must, and computes the expected maximum
// for each accepted query. It then compares every response, field by field,
// with the oldest outstanding query.
// ---------------------------------------------------------------------------
module line_tree_checker
   import lcmt_pkg::*;
#(
   parameter int SPAN_HALF  = SPAN_HALF_DEF,
   parameter int TREE_NODES = TREE_NODES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic                     req_type,
   input  logic signed [COEF_W-1:0] req_slope,
   input  logic signed [COEF_W-1:0] req_intercept,
   input  logic signed [XIN_W-1:0]  req_x_point,
   input  logic                     rsp_valid,
   input  logic signed [OUT_W-1:0]  rsp_max_value,
   input  logic                     rsp_empty_res,
   output int                       fail_count,
   output int                       pending
);

   typedef struct {
      logic signed [OUT_W-1:0] value;
      logic                    empty;
   } peak_rec_type;

   int           node_slope [TREE_NODES];
   int           node_icpt  [TREE_NODES];
   bit           node_used  [TREE_NODES];
   peak_rec_type expected_peaks [$];
   peak_rec_type oldest;
   int           mismatches = 0;
   int           waiting = 0;

   assign fail_count = mismatches;
   assign pending    = waiting;

   function automatic longint line_at(longint k, longint c, longint u);
      return k * (u - SPAN_HALF) + c;
   endfunction

   function automatic void insert_line(longint k, longint c);
      longint      lo, hi, mid, nk, nc, tl, tr, vl, vr, tk, tc;
      int unsigned idx;
      idx = 1;
      lo  = 0;
      hi  = 2 * SPAN_HALF;
      while (idx < TREE_NODES) begin
         if (!node_used[idx]) begin
            node_used[idx]  = 1'b1;
            node_slope[idx] = int'(k);
            node_icpt[idx]  = int'(c);
            return;
         end
         nk = node_slope[idx];
         nc = node_icpt[idx];
         tl = line_at(nk, nc, lo);
         tr = line_at(nk, nc, hi);
         vl = line_at(k, c, lo);
         vr = line_at(k, c, hi);
         if (tl >= vl && tr >= vr)
            return;
         if (tl < vl && tr < vr) begin
            node_slope[idx] = int'(k);
            node_icpt[idx]  = int'(c);
            return;
         end
         // keep the left-end winner in nk/nc
         if (tl < vl) begin
            tk = nk; tc = nc;
            nk = k;  nc = c;
            k  = tk; c  = tc;
         end
         mid = (lo + hi) >>> 1;
         if (line_at(nk, nc, mid) > line_at(k, c, mid)) begin
            node_slope[idx] = int'(nk);
            node_icpt[idx]  = int'(nc);
            idx = idx * 2 + 1;
            lo  = mid + 1;
         end else begin
            node_slope[idx] = int'(k);
            node_icpt[idx]  = int'(c);
            k   = nk;
            c   = nc;
            idx = idx * 2;
            hi  = mid;
         end
      end
   endfunction

   function automatic peak_rec_type peak_at(logic signed [XIN_W-1:0] xq);
      longint       x, u, lo, hi, mid, v, best;
      int unsigned  idx;
      bit           found;
      peak_rec_type r;
      x = xq;
      if (x < -SPAN_HALF) x = -SPAN_HALF;
      if (x > SPAN_HALF)  x = SPAN_HALF;
      u     = x + SPAN_HALF;
      idx   = 1;
      lo    = 0;
      hi    = 2 * SPAN_HALF;
      best  = 0;
      found = 1'b0;
      while (idx < TREE_NODES && node_used[idx]) begin
         v = line_at(node_slope[idx], node_icpt[idx], u);
         if (!found || v > best)
            best = v;
         found = 1'b1;
         if (lo == hi)
            break;
         mid = (lo + hi) >>> 1;
         if (u <= mid) begin
            idx = idx * 2;
            hi  = mid;
         end else begin
            idx = idx * 2 + 1;
            lo  = mid + 1;
         end
      end
      r.value = '0;
      if (found)
         r.value = OUT_W'(best);
      r.empty = !found;
      return r;
   endfunction

   task automatic flag(string what);
      mismatches++;
      if (mismatches <= 10)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (node_used[i])
            node_used[i] = 1'b0;
         expected_peaks.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_peaks.size() == 0) begin
               flag($sformatf("response with no query outstanding: value %0d empty %0b",
                              rsp_max_value, rsp_empty_res));
            end else begin
               oldest = expected_peaks.pop_front();
               if (rsp_max_value !== oldest.value)
                  flag($sformatf("max_value expected %0d got %0d",
                                 oldest.value, rsp_max_value));
               if (rsp_empty_res !== oldest.empty)
                  flag($sformatf("empty_res expected %0b got %0b",
                                 oldest.empty, rsp_empty_res));
            end
         end
         if (start && !busy) begin
            if (req_type == REQ_QUERY)
               expected_peaks.push_back(peak_at(req_x_point));
            else
               insert_line(req_slope, req_intercept);
         end
      end
      waiting = expected_peaks.size();
   end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Regression bench for the maximum line tree core. Drives directed queries
// and line inserts (empty tree, clamped coordinates, ties, replacement,
// extreme coefficients), then random queries and inserts, many of the inserts
// tangent lines of a parabola so that inserts walk deep into the tree. A
// separate checker predicts and compares every response; this module gives
// the verdict.
// ---------------------------------------------------------------------------
module tb;
   import lcmt_pkg::*;

   localparam int WATCH_LIMIT  = 30000;
   localparam int DRAIN_CYCLES = 200;
   localparam int DEEP_ITEMS   = 730;
   localparam int LATE_ITEMS   = 300;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic                     req_type = REQ_ADD;
   logic signed [COEF_W-1:0] req_slope = '0;
   logic signed [COEF_W-1:0] req_intercept = '0;
   logic signed [XIN_W-1:0]  req_x_point = '0;
   logic                     rsp_valid;
   logic signed [OUT_W-1:0]  rsp_max_value;
   logic                     rsp_empty_res;
   int                       fail_count;
   int                       pending;
   int                       quiet_cycles = 0;
   bit                       idle_on = 1'b1;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   li_chao_max_line_tree_core dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_slope     (req_slope),
      .req_intercept (req_intercept),
      .req_x_point   (req_x_point),
      .rsp_valid     (rsp_valid),
      .rsp_max_value (rsp_max_value),
      .rsp_empty_res (rsp_empty_res)
   );

   line_tree_checker chk (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_slope     (req_slope),
      .req_intercept (req_intercept),
      .req_x_point   (req_x_point),
      .rsp_valid     (rsp_valid),
      .rsp_max_value (rsp_max_value),
      .rsp_empty_res (rsp_empty_res),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < WATCH_LIMIT)
         @(posedge clock);
      $display("li_chao_max_line_tree_core regression: fail");
      $finish;
   end

   // present one transaction at a falling edge and hold it until taken
   task automatic issue(logic kind, logic signed [COEF_W-1:0] k,
                        logic signed [COEF_W-1:0] c, logic signed [XIN_W-1:0] x);
      req_type      = kind;
      req_slope     = k;
      req_intercept = c;
      req_x_point   = x;
      start         = 1'b1;
      while (busy !== 1'b0)
         @(negedge clock);
      @(negedge clock);
   endtask

   task automatic maybe_idle();
      if (idle_on && $urandom_range(0, 2) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
   endtask

   task automatic random_item(bit late);
      int unsigned              pick;
      int                       a;
      logic signed [COEF_W-1:0] k;
      logic signed [COEF_W-1:0] c;
      logic signed [XIN_W-1:0]  x;
      pick = $urandom_range(0, 99);
      k    = $urandom;
      c    = $urandom;
      if ($urandom_range(0, 99) < 80)
         x = XIN_W'(int'($urandom_range(0, 2 * SPAN_HALF_DEF)) - SPAN_HALF_DEF);
      else
         x = XIN_W'($urandom);
      if (pick < 45) begin
         issue(REQ_QUERY, k, c, x);
      end else if (pick < (late ? 60 : 85)) begin
         // tangent of y = x*x near a, each wins only a narrow window
         a = int'($urandom_range(0, 2 * SPAN_HALF_DEF)) - SPAN_HALF_DEF;
         k = 2 * a + int'($urandom_range(0, 2)) - 1;
         c = -(a * a) + int'($urandom_range(0, 6)) - 3;
         issue(REQ_ADD, k, c, x);
      end else if (!late) begin
         k = int'($urandom_range(0, 4096)) - 2048;
         c = int'($urandom_range(0, 1 << 22)) - (1 << 21);
         issue(REQ_ADD, k, c, x);
      end else begin
         issue(REQ_ADD, k, c, x);
      end
      maybe_idle();
   endtask

   initial begin
      int n;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      issue(REQ_QUERY, 0, 0, 0);
      issue(REQ_QUERY, 0, 0, -12'sd2048);
      issue(REQ_QUERY, 0, 0, 12'sd2047);
      issue(REQ_QUERY, 0, 0, -12'sd1024);
      issue(REQ_ADD, -1, 0, 0);
      issue(REQ_ADD, 1, 0, 0);
      issue(REQ_ADD, -1, 0, 0);
      issue(REQ_ADD, 0, 32'sh8000_0000, 0);
      issue(REQ_QUERY, 0, 0, -1);
      issue(REQ_QUERY, 0, 0, 0);
      issue(REQ_QUERY, 0, 0, 1);
      issue(REQ_QUERY, 0, 0, -12'sd1025);
      issue(REQ_QUERY, 0, 0, 12'sd1025);
      issue(REQ_ADD, 1, 1, 0);
      issue(REQ_QUERY, 0, 0, 0);
      issue(REQ_QUERY, 0, 0, 12'sd512);

      for (n = 0; n < DEEP_ITEMS; n++) begin
         if (n % 64 == 0)
            idle_on = $urandom_range(0, 2) != 0;
         random_item(1'b0);
      end

      idle_on = 1'b0;
      issue(REQ_ADD, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
      issue(REQ_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
      issue(REQ_QUERY, 0, 0, -12'sd1024);
      issue(REQ_QUERY, 0, 0, 12'sd1024);
      issue(REQ_QUERY, 0, 0, 0);
      issue(REQ_ADD, 0, 32'sh7FFF_FFFF, 0);
      issue(REQ_QUERY, 0, 0, 0);
      issue(REQ_QUERY, 0, 0, -12'sd2048);

      for (n = 0; n < LATE_ITEMS; n++)
         random_item(1'b1);

      start = 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("li_chao_max_line_tree_core regression: pass");
      else
         $display("li_chao_max_line_tree_core regression: fail");
      $finish;
   end

endmodule

FILE: files.f
sv/lcmt_pkg.sv
sv/lcmt_eval_unit.sv
sv/lcmt_node_store.sv
sv/li_chao_max_line_tree_core.sv
sv/lcmt_checker.sv
test/line_tree_checker.sv
test/tb.sv
